### rtl/core/mspd_pkg.sv
// ----------------------------------------------------------------------------
// mspd_pkg: shared types and constants of the motor speed PD controller
// Field widths, register codes, reset values and the controller state type.
// ----------------------------------------------------------------------------
package mspd_pkg;

  // defaults of the top-level parameters
  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int TIMER_WIDTH_DEF    = 32;

  // field and datapath widths
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int STAMP_W    = 32;
  localparam int DUTY_W     = 16;
  localparam int SPEED_W    = 32;
  localparam int GAIN_W     = 16;
  localparam int ERR_W      = 34;
  localparam int DRV_W      = ERR_W + 1;
  localparam int PROD_W     = DRV_W + GAIN_W;
  localparam int CORR_W     = PROD_W + 1;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  // register reset values
  localparam logic [15:0] TARGET_RPM_RST  = 16'd2500;
  localparam logic [15:0] GAIN_P_RST      = 16'd256;
  localparam logic [15:0] GAIN_D_RST      = 16'd256;
  localparam logic [15:0] DEADBAND_RST    = 16'd100;
  localparam logic [31:0] MIN_PERIOD_RST  = 32'd800000;
  localparam logic [31:0] MAX_PERIOD_RST  = 32'd4800000;
  localparam logic [15:0] SPEED_GUARD_RST = 16'd100;
  localparam logic [31:0] RPM_SCALE_RST   = 32'd2400000000;

  localparam logic [DUTY_W-1:0] DUTY_MAX = {DUTY_W{1'b1}};

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TARGET_RPM  = 3'd0,
    REG_GAIN_P      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_DEADBAND    = 3'd3,
    REG_MIN_PERIOD  = 3'd4,
    REG_MAX_PERIOD  = 3'd5,
    REG_SPEED_GUARD = 3'd6,
    REG_RPM_SCALE   = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    CMD_CAPTURE = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_e;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_CAP_DIFF = 10'b00_0000_0010,
    ST_CAP_WIN  = 10'b00_0000_0100,
    ST_DIV      = 10'b00_0000_1000,
    ST_ERR      = 10'b00_0001_0000,
    ST_DRV      = 10'b00_0010_0000,
    ST_MUL      = 10'b00_0100_0000,
    ST_TRUNC    = 10'b00_1000_0000,
    ST_CORR     = 10'b01_0000_0000,
    ST_DUTY     = 10'b10_0000_0000
  } state_e;

endpackage

### rtl/core/mspd_div_serial.sv
// ----------------------------------------------------------------------------
// mspd_div_serial: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle; done pulses after WIDTH steps.
// ----------------------------------------------------------------------------
module mspd_div_serial #(
  parameter int WIDTH = mspd_pkg::SPEED_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quotient_o
);
  localparam int CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [WIDTH-1:0] rem_q, quo_q, den_q;
  logic [WIDTH:0]   trial, diff;

  // shift the next dividend bit into the remainder, try the subtract
  assign trial = {rem_q, quo_q[WIDTH-1]};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(WIDTH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= diff[WIDTH] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
      quo_q <= {quo_q[WIDTH-2:0], ~diff[WIDTH]};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/core/mspd_mul_serial.sv
// ----------------------------------------------------------------------------
// mspd_mul_serial: digit-serial signed multiplier
// Radix-4, most significant digit first; the top gain digit carries the sign.
// ----------------------------------------------------------------------------
module mspd_mul_serial #(
  parameter int XW = mspd_pkg::DRV_W,
  parameter int GW = mspd_pkg::GAIN_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [XW-1:0]    x_i,
  input  logic signed [GW-1:0]    g_i,
  output logic                    done_o,
  output logic signed [XW+GW-1:0] prod_o
);
  localparam int PW   = XW + GW;
  localparam int Dig  = GW / 2;
  localparam int CntW = (Dig > 1) ? $clog2(Dig) : 1;

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic signed [XW-1:0] x_q;
  logic signed [XW+1:0] x3_q;
  logic [GW-1:0]        g_q;
  logic signed [PW-1:0] acc_q;
  logic signed [PW-1:0] x1, x2, pos_sel, neg_sel;
  logic [1:0]           digit;

  assign x1    = PW'(x_q);
  assign x2    = x1 <<< 1;
  assign digit = g_q[GW-1:GW-2];

  always_comb begin
    unique case (digit)
      2'b00:   pos_sel = '0;
      2'b01:   pos_sel = x1;
      2'b10:   pos_sel = x2;
      default: pos_sel = PW'(x3_q);
    endcase
    // top digit: the sign bit weighs minus two
    unique case (digit)
      2'b00:   neg_sel = '0;
      2'b01:   neg_sel = x1;
      2'b10:   neg_sel = -x2;
      default: neg_sel = -x1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Dig - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      x3_q  <= (XW+2)'(x_i) + ((XW+2)'(x_i) <<< 1);
      g_q   <= g_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= (cnt_q == '0) ? neg_sel : (acc_q <<< 2) + pos_sel;
      g_q   <= g_q << 2;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### rtl/core/motor_speed_pd_controller.sv
// ----------------------------------------------------------------------------
// motor_speed_pd_controller: motor speed PD controller with period capture
// Capture items update the measured period; control ticks compute speed,
// run the PD law and emit the saturated duty with the speed.
// ----------------------------------------------------------------------------
// A capture item occupies the block through ST_CAP_DIFF and ST_CAP_WIN and gives
// no result. A control tick runs ST_DIV, ST_ERR, ST_DRV, ST_MUL, ST_TRUNC, ST_CORR
// and ST_DUTY; the next item is taken only after the tick's result is loaded.
// The 32-step bit-serial divider and the 8-digit serial multipliers dominate.
// Reset (async, active low) loads the register defaults and clears the controller state.
// A waiting result does not block acceptance of the next item.
module motor_speed_pd_controller #(
  parameter int GAIN_FRAC_BITS = mspd_pkg::GAIN_FRAC_BITS_DEF,
  parameter int TIMER_WIDTH    = mspd_pkg::TIMER_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input item stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mspd_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] capture_time
  input  logic                            s_axis_tuser,   // [0] command
  // result item stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mspd_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] duty, [47:16] speed_rpm
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [mspd_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [mspd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import mspd_pkg::*;

  // rounding bias that turns the arithmetic shift into truncation toward zero
  localparam logic signed [PROD_W-1:0] TruncBias =
    PROD_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  state_e state_q, state_d;

  // configuration registers
  logic [15:0]        target_q, deadband_q, guard_q;
  logic signed [15:0] gain_p_q, gain_d_q;
  logic [31:0]        min_period_q, max_period_q, scale_q;

  // controller state
  logic [TIMER_WIDTH-1:0]   prev_stamp_q, prev_stamp_d;
  logic [TIMER_WIDTH-1:0]   period_q, period_d;
  logic [SPEED_W-1:0]       speed_q, speed_d;
  logic signed [ERR_W-1:0]  prev_err_q, prev_err_d;
  logic [DUTY_W-1:0]        duty_q, duty_d;

  // working registers of one item
  logic [TIMER_WIDTH-1:0]   stamp_q, diff_q;
  logic                     later_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [DRV_W-1:0]  drv_q;
  logic signed [PROD_W-1:0] p_term_q, d_term_q;
  logic signed [CORR_W-1:0] corr_q;
  logic                     mul_go_q;

  // output register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic in_accept, out_load;
  logic [TIMER_WIDTH:0] stamp_sub;
  logic guarded, outside;
  logic div_start, div_done;
  logic [SPEED_W-1:0] div_quo;
  logic p_done, d_done;
  logic signed [PROD_W-1:0] p_prod, d_prod, p_adj, d_adj;
  logic signed [CORR_W-1:0] band_s, duty_sum;
  logic in_band;
  logic [DUTY_W-1:0] duty_sat;

  // the block takes one item at a time; the output register parts the result
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign div_start     = in_accept && (s_axis_tuser == CMD_TICK);
  // load the result only once the previous one has left
  assign out_load      = (state_q == ST_DUTY) && (!out_valid_q || m_axis_tready);

  // capture: borrow of the subtract tells whether the stamp moved forward
  assign stamp_sub = {1'b0, stamp_q} - {1'b0, prev_stamp_q};
  assign guarded   = speed_q > SPEED_W'(guard_q);
  assign outside   = (STAMP_W'(diff_q) < min_period_q) || (STAMP_W'(diff_q) > max_period_q);

  // speed = scale / period, one quotient bit per cycle
  mspd_div_serial #(
    .WIDTH(SPEED_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (scale_q),
    .divisor_i  (SPEED_W'(period_q)),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // P and D products run side by side, two gain bits per cycle
  mspd_mul_serial #(
    .XW(DRV_W),
    .GW(GAIN_W)
  ) u_mul_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go_q),
    .x_i     (DRV_W'(err_q)),
    .g_i     (gain_p_q),
    .done_o  (p_done),
    .prod_o  (p_prod)
  );

  mspd_mul_serial #(
    .XW(DRV_W),
    .GW(GAIN_W)
  ) u_mul_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go_q),
    .x_i     (drv_q),
    .g_i     (gain_d_q),
    .done_o  (d_done),
    .prod_o  (d_prod)
  );

  // truncate the products of the Q8.8 gains toward zero
  assign p_adj = p_prod + (p_prod[PROD_W-1] ? TruncBias : '0);
  assign d_adj = d_prod + (d_prod[PROD_W-1] ? TruncBias : '0);

  // deadband check and saturating accumulate work side by side
  assign band_s   = signed'(CORR_W'(deadband_q));
  assign in_band  = !((corr_q > band_s) || (corr_q < -band_s));
  assign duty_sum = signed'(CORR_W'(duty_q)) + corr_q;

  always_comb begin
    if (duty_sum[CORR_W-1]) begin
      duty_sat = '0;
    end else if (duty_sum > signed'(CORR_W'(DUTY_MAX))) begin
      duty_sat = DUTY_MAX;
    end else begin
      duty_sat = duty_sum[DUTY_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    prev_stamp_d = prev_stamp_q;
    period_d     = period_q;
    speed_d      = speed_q;
    prev_err_d   = prev_err_q;
    duty_d       = duty_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (s_axis_tuser == CMD_TICK) ? ST_DIV : ST_CAP_DIFF;
        end
      end
      ST_CAP_DIFF: begin
        // record the stamp whether or not the period changes
        prev_stamp_d = stamp_q;
        state_d      = ST_CAP_WIN;
      end
      ST_CAP_WIN: begin
        // drop a period outside the window while running above the guard
        if (later_q && !(guarded && outside)) begin
          period_d = diff_q;
        end
        state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) begin
          speed_d = (period_q == '0) ? '0 : div_quo;
          state_d = ST_ERR;
        end
      end
      ST_ERR: state_d = ST_DRV;
      ST_DRV: begin
        prev_err_d = err_q;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        if (p_done && d_done) begin
          state_d = ST_TRUNC;
        end
      end
      ST_TRUNC: state_d = ST_CORR;
      ST_CORR:  state_d = ST_DUTY;
      ST_DUTY: begin
        // hold here until the output register is free
        if (out_load) begin
          duty_d  = in_band ? duty_q : duty_sat;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      target_q     <= TARGET_RPM_RST;
      gain_p_q     <= GAIN_P_RST;
      gain_d_q     <= GAIN_D_RST;
      deadband_q   <= DEADBAND_RST;
      min_period_q <= MIN_PERIOD_RST;
      max_period_q <= MAX_PERIOD_RST;
      guard_q      <= SPEED_GUARD_RST;
      scale_q      <= RPM_SCALE_RST;
      prev_stamp_q <= '0;
      period_q     <= '0;
      speed_q      <= '0;
      prev_err_q   <= '0;
      duty_q       <= '0;
      mul_go_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      prev_stamp_q <= prev_stamp_d;
      period_q     <= period_d;
      speed_q      <= speed_d;
      prev_err_q   <= prev_err_d;
      duty_q       <= duty_d;
      // start the multipliers once the derivative is registered
      mul_go_q     <= (state_q == ST_DRV);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_addr_i))
          REG_TARGET_RPM:  target_q     <= cfg_wdata_i[15:0];
          REG_GAIN_P:      gain_p_q     <= cfg_wdata_i[15:0];
          REG_GAIN_D:      gain_d_q     <= cfg_wdata_i[15:0];
          REG_DEADBAND:    deadband_q   <= cfg_wdata_i[15:0];
          REG_MIN_PERIOD:  min_period_q <= cfg_wdata_i;
          REG_MAX_PERIOD:  max_period_q <= cfg_wdata_i;
          REG_SPEED_GUARD: guard_q      <= cfg_wdata_i[15:0];
          REG_RPM_SCALE:   scale_q      <= cfg_wdata_i;
        endcase
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stamp_q <= s_axis_tdata[TIMER_WIDTH-1:0];
    end
    if (state_q == ST_CAP_DIFF) begin
      diff_q  <= stamp_sub[TIMER_WIDTH-1:0];
      later_q <= !stamp_sub[TIMER_WIDTH] && (stamp_sub[TIMER_WIDTH-1:0] != '0);
    end
    if (state_q == ST_ERR) begin
      err_q <= signed'(ERR_W'(target_q)) - signed'(ERR_W'(speed_q));
    end
    if (state_q == ST_DRV) begin
      drv_q <= DRV_W'(err_q) - DRV_W'(prev_err_q);
    end
    if (state_q == ST_TRUNC) begin
      p_term_q <= p_adj >>> GAIN_FRAC_BITS;
      d_term_q <= d_adj >>> GAIN_FRAC_BITS;
    end
    if (state_q == ST_CORR) begin
      corr_q <= CORR_W'(p_term_q) + CORR_W'(d_term_q);
    end
    if (out_load) begin
      out_data_q <= {speed_q, duty_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### rtl/core/mspd_checker.sv
// ----------------------------------------------------------------------------
// mspd_checker: port-level checks of the motor speed PD controller
// Watches the stream handshakes over time; bound to the top level below.
// ----------------------------------------------------------------------------
module mspd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mspd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item at a time: no acceptance in the cycle after an acceptance
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("ready high right after an accepted item");

  // a capture item frees the input again after ST_CAP_DIFF and ST_CAP_WIN
  a_capture_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tuser |-> ##3 s_axis_tready)
    else $error("capture item did not finish in three cycles");

  // a result never appears right after an item was taken
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(in_acc) && !$past(in_acc, 2))
    else $error("result appeared too soon after an item");

endmodule

bind motor_speed_pd_controller mspd_checker u_mspd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/mspd_speed_loop_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspd_speed_loop_check: prediction and comparison for the speed PD controller
// Watches the register port and both streams, keeps its own copy of the
// registers and the control state, and compares each result item with the
// oldest predicted duty and speed.
// ----------------------------------------------------------------------------
module mspd_speed_loop_check
  import mspd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [31:0] capture_time
  input  logic                  s_axis_tuser,   // [0] command
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] duty, [47:16] speed_rpm
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    results_owed_o
);

  typedef struct packed {
    logic [SPEED_W-1:0] speed_rpm;
    logic [DUTY_W-1:0]  duty;
  } duty_speed_t;

  duty_speed_t owed_q[$];
  int          fails;

  // register copies
  logic [15:0]              target_rpm_q;
  logic signed [GAIN_W-1:0] gain_p_q;
  logic signed [GAIN_W-1:0] gain_d_q;
  logic [15:0]              deadband_q;
  logic [31:0]              min_period_q;
  logic [31:0]              max_period_q;
  logic [15:0]              speed_guard_q;
  logic [31:0]              rpm_scale_q;

  // control state
  logic [STAMP_W-1:0] last_stamp_q;
  logic [31:0]        period_q;
  logic [SPEED_W-1:0] speed_q;
  longint             last_err_q;
  logic [DUTY_W-1:0]  duty_q;

  // Q8.8 product, truncated toward zero
  function automatic longint gain_term(logic signed [GAIN_W-1:0] gain, longint x);
    return (longint'(gain) * x) / (longint'(1) <<< GAIN_FRAC_BITS_DEF);
  endfunction

  task automatic advance_controller(input cmd_e cmd, input logic [STAMP_W-1:0] stamp);
    logic [31:0] lapse;
    longint      err;
    longint      corr;
    longint      acc;
    if (cmd == CMD_CAPTURE) begin
      if (stamp > last_stamp_q) begin
        lapse = stamp - last_stamp_q;
        if (!(speed_q > speed_guard_q && (lapse < min_period_q || lapse > max_period_q)))
          period_q = lapse;
      end
      last_stamp_q = stamp;
    end else begin
      speed_q = (period_q != 0) ? rpm_scale_q / period_q : '0;
      err     = longint'(target_rpm_q) - longint'(speed_q);
      corr    = gain_term(gain_p_q, err) + gain_term(gain_d_q, err - last_err_q);
      if (corr < -longint'(deadband_q) || corr > longint'(deadband_q)) begin
        acc = longint'(duty_q) + corr;
        if (acc < 0) acc = 0;
        if (acc > longint'(DUTY_MAX)) acc = longint'(DUTY_MAX);
        duty_q = acc[DUTY_W-1:0];
      end
      last_err_q = err;
      owed_q.push_back('{speed_rpm: speed_q, duty: duty_q});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    duty_speed_t got;
    duty_speed_t want;
    if (!rst_ni) begin
      target_rpm_q   = TARGET_RPM_RST;
      gain_p_q       = GAIN_P_RST;
      gain_d_q       = GAIN_D_RST;
      deadband_q     = DEADBAND_RST;
      min_period_q   = MIN_PERIOD_RST;
      max_period_q   = MAX_PERIOD_RST;
      speed_guard_q  = SPEED_GUARD_RST;
      rpm_scale_q    = RPM_SCALE_RST;
      last_stamp_q   = '0;
      period_q       = '0;
      speed_q        = '0;
      last_err_q     = 0;
      duty_q         = '0;
      owed_q.delete();
      fails          = 0;
      fail_count_o   <= 0;
      results_owed_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = duty_speed_t'(m_axis_tdata);
        if (owed_q.size() == 0) begin
          $error("duty/speed_rpm: result with none expected, duty %0d speed_rpm %0d",
                 got.duty, got.speed_rpm);
          fails++;
        end else begin
          want = owed_q.pop_front();
          if (got.duty !== want.duty) begin
            $error("duty: expected %0d, got %0d", want.duty, got.duty);
            fails++;
          end
          if (got.speed_rpm !== want.speed_rpm) begin
            $error("speed_rpm: expected %0d, got %0d", want.speed_rpm, got.speed_rpm);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_TARGET_RPM:  target_rpm_q  = cfg_wdata_i[15:0];
          REG_GAIN_P:      gain_p_q      = cfg_wdata_i[GAIN_W-1:0];
          REG_GAIN_D:      gain_d_q      = cfg_wdata_i[GAIN_W-1:0];
          REG_DEADBAND:    deadband_q    = cfg_wdata_i[15:0];
          REG_MIN_PERIOD:  min_period_q  = cfg_wdata_i;
          REG_MAX_PERIOD:  max_period_q  = cfg_wdata_i;
          REG_SPEED_GUARD: speed_guard_q = cfg_wdata_i[15:0];
          REG_RPM_SCALE:   rpm_scale_q   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        advance_controller(cmd_e'(s_axis_tuser), s_axis_tdata[STAMP_W-1:0]);
      fail_count_o   <= fails;
      results_owed_o <= owed_q.size();
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the motor speed PD controller
// Drives capture and tick items with random gaps and a stalling result
// receiver, sweeps register settings between phases, and takes the error
// count from the prediction checker beside the block.
// ----------------------------------------------------------------------------
module tb;
  import mspd_pkg::*;

  localparam int RESET_CYCLES    = 11;
  // let any capture or tick finish before touching
  // the registers
  localparam int SETTLE_CYCLES   = 60;
  // slowest quiet stretch is a tick plus the longest receiver stall plus a settle pause
  localparam int QUIET_LIMIT     = 2000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 170;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;    // [31:0] capture_time
  logic                  s_axis_tuser  = 1'b0;  // [0] command
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;          // [15:0] duty, [47:16] speed_rpm
  logic                  cfg_we        = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

  int          fail_count;
  int          results_owed;
  int          quiet_cycles = 0;
  int unsigned hold_left    = 0;
  int unsigned hold_len;
  logic        steady       = 1'b0;   // high: neither side idles
  logic [31:0] setting [8];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  motor_speed_pd_controller dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata)
  );

  mspd_speed_loop_check check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fail_count),
    .results_owed_o (results_owed)
  );

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned idle_length();
    int unsigned roll = $urandom_range(99, 0);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Draw a register value: an extreme, a full-width random pattern, or a
  // value from the range a running motor actually uses.
  function automatic logic [31:0] pick_setting(cfg_reg_e r);
    int unsigned roll = $urandom_range(7, 0);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] typ;
    case (r)
      REG_TARGET_RPM: begin
        lo = 0; hi = 32'hFFFF; typ = $urandom_range(5000, 0);
      end
      REG_GAIN_P, REG_GAIN_D: begin
        // most negative and most positive Q8.8 gains
        lo = 32'h8000; hi = 32'h7FFF;
        typ = ($urandom_range(1200, 0) - 600) & 32'hFFFF;
      end
      REG_DEADBAND: begin
        lo = 0; hi = 32'hFFFF; typ = $urandom_range(300, 0);
      end
      REG_MIN_PERIOD: begin
        lo = 0; hi = 32'hFFFF_FFFF; typ = $urandom_range(1000000, 200000);
      end
      REG_MAX_PERIOD: begin
        lo = 0; hi = 32'hFFFF_FFFF; typ = $urandom_range(6000000, 2000000);
      end
      REG_SPEED_GUARD: begin
        lo = 0; hi = 32'hFFFF; typ = $urandom_range(3000, 0);
      end
      default: begin
        lo = 1; hi = 32'hFFFF_FFFF;
        typ = $urandom_range(1, 0) ? 32'(RPM_SCALE_RST) : $urandom;
      end
    endcase
    if (roll == 0) return lo;
    if (roll == 1) return hi;
    if (roll == 2) return $urandom & (lo | hi);
    return typ;
  endfunction

  // Offer one item after a random gap and hold it until taken. With no gap,
  // valid stays high and only the payload changes.
  task automatic send_item(input cmd_e cmd, input logic [31:0] stamp);
    int unsigned gap = steady ? 0 : idle_length();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= stamp;
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Drop valid, wait for every predicted result, then let the block settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= r;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result receiver: random stalls of random length, none while steady.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      hold_len = (steady || $urandom_range(3, 0) != 0) ? 0 : idle_length();
      if (hold_len != 0) begin
        hold_left     <= hold_len - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles in which no item moves on any channel.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned roll;
    logic [31:0] clock_stamp;
    cfg_reg_e    r;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset settings: tick with zero period, stamp not later than
    // the previous one, a period taken while slow, a far stamp rejected by
    // the window, window edges accepted, one past the edge rejected.
    send_item(CMD_TICK, 32'hFFFF_FFFF);
    send_item(CMD_CAPTURE, 32'd0);
    send_item(CMD_CAPTURE, 32'd1000000);
    send_item(CMD_TICK, 32'd0);
    send_item(CMD_CAPTURE, 32'hFFFF_FFFF);
    send_item(CMD_CAPTURE, 32'd5);
    send_item(CMD_CAPTURE, 32'd800005);
    send_item(CMD_CAPTURE, 32'd5600005);
    send_item(CMD_CAPTURE, 32'd10400006);
    send_item(CMD_TICK, 32'd0);

    // Highest target, extreme gains, no deadband, open window, zero scale:
    // speed reads zero with a nonzero period and duty saturates high.
    wait_drained();
    write_reg(REG_TARGET_RPM, 32'hFFFF);
    write_reg(REG_GAIN_P, 32'h7FFF);
    write_reg(REG_GAIN_D, 32'h8000);
    write_reg(REG_DEADBAND, 32'd0);
    write_reg(REG_MIN_PERIOD, 32'd0);
    write_reg(REG_MAX_PERIOD, 32'hFFFF_FFFF);
    write_reg(REG_SPEED_GUARD, 32'hFFFF);
    write_reg(REG_RPM_SCALE, 32'd0);
    send_item(CMD_TICK, 32'd0);
    send_item(CMD_CAPTURE, 32'd10400007);
    send_item(CMD_TICK, 32'd0);
    send_item(CMD_TICK, 32'd0);

    // Zero target against the largest speed, gains of swapped sign, widest
    // deadband: the correction stays far outside the band and duty stays high.
    wait_drained();
    write_reg(REG_TARGET_RPM, 32'd0);
    write_reg(REG_GAIN_P, 32'h8000);
    write_reg(REG_GAIN_D, 32'h7FFF);
    write_reg(REG_DEADBAND, 32'hFFFF);
    write_reg(REG_RPM_SCALE, 32'hFFFF_FFFF);
    send_item(CMD_TICK, 32'd0);
    send_item(CMD_TICK, 32'd0);
    send_item(CMD_TICK, 32'd0);

    // Random phases: fresh settings each time, mostly plausible capture
    // sequences with ticks between them, plus backward and wild stamps.
    clock_stamp = 32'd10400007;
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      r = r.first();
      repeat (r.num()) begin
        setting[r] = pick_setting(r);
        write_reg(r, setting[r]);
        r = r.next();
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) steady = ($urandom_range(3, 0) == 0);
        // hold the sender until the block has answered everything
        if ($urandom_range(99, 0) == 0) wait_drained();
        roll = $urandom_range(99, 0);
        if (roll < 35) begin
          send_item(CMD_TICK, $urandom);
        end else if (roll < 75) begin
          clock_stamp += $urandom_range(setting[REG_MAX_PERIOD], setting[REG_MIN_PERIOD]);
          send_item(CMD_CAPTURE, clock_stamp);
        end else if (roll < 90) begin
          clock_stamp += $urandom_range(2000000, 0);
          send_item(CMD_CAPTURE, clock_stamp);
        end else begin
          send_item(CMD_CAPTURE, $urandom);
        end
      end
    end

    steady = 1'b0;
    wait_drained();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
